### rtl/spq_pkg.sv
// Package for the sorted priority queue: operation and status codes, the
// control struct broadcast to the cell chain, and parameter defaults.
// Has no dependencies of its own.
package spq_pkg;

   localparam int DEPTH_DEFAULT         = 16;
   localparam int PAYLOAD_WIDTH_DEFAULT = 32;
   localparam int PRIO_WIDTH_DEFAULT    = 16;
   localparam int STATUS_WIDTH          = 2;

   localparam logic MODE_ENQUEUE = 1'b0;
   localparam logic MODE_DEQUEUE = 1'b1;

   localparam logic [STATUS_WIDTH-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic push;
      logic pop;
   } spq_ctl_type;

endpackage

### rtl/spq_if.sv
// Valid/ready channel interfaces for the request and response sides of the
// sorted priority queue. Depends on spq_pkg for width defaults.
interface spq_req_if #(
   parameter int PAYLOAD_WIDTH = spq_pkg::PAYLOAD_WIDTH_DEFAULT,
   parameter int PRIO_WIDTH    = spq_pkg::PRIO_WIDTH_DEFAULT
) ();
   logic                     valid;
   logic                     ready;
   logic                     mode;
   logic [PAYLOAD_WIDTH-1:0] payload;
   logic [PRIO_WIDTH-1:0]    prio;

   modport source (output valid, mode, payload, prio, input ready);
   modport sink   (input valid, mode, payload, prio, output ready);
endinterface

interface spq_rsp_if #(
   parameter int PAYLOAD_WIDTH = spq_pkg::PAYLOAD_WIDTH_DEFAULT,
   parameter int PRIO_WIDTH    = spq_pkg::PRIO_WIDTH_DEFAULT,
   parameter int OCC_WIDTH     = $clog2(spq_pkg::DEPTH_DEFAULT + 1)
) ();
   logic                                valid;
   logic                                ready;
   logic                                took_item;
   logic [PAYLOAD_WIDTH-1:0]            out_payload;
   logic [PRIO_WIDTH-1:0]               out_prio;
   logic [spq_pkg::STATUS_WIDTH-1:0]    status;
   logic [OCC_WIDTH-1:0]                occupancy;

   modport source (output valid, took_item, out_payload, out_prio, status, occupancy,
                   input ready);
   modport sink   (input valid, took_item, out_payload, out_prio, status, occupancy,
                   output ready);
endinterface

### rtl/spq_cell.sv
// One slot of the sorted chain: holds an entry and, on each operation, keeps
// it, takes the new entry, or takes a neighbor's entry. Depends on spq_pkg.
module spq_cell #(
   parameter int PAYLOAD_WIDTH = spq_pkg::PAYLOAD_WIDTH_DEFAULT,
   parameter int PRIO_WIDTH    = spq_pkg::PRIO_WIDTH_DEFAULT
) (
   input  logic                     clock,
   input  spq_pkg::spq_ctl_type     ctl,
   input  logic                     occupied,
   input  logic [PRIO_WIDTH-1:0]    new_prio,
   input  logic [PAYLOAD_WIDTH-1:0] new_payload,
   input  logic                     left_lt,
   input  logic [PRIO_WIDTH-1:0]    left_prio,
   input  logic [PAYLOAD_WIDTH-1:0] left_payload,
   input  logic [PRIO_WIDTH-1:0]    right_prio,
   input  logic [PAYLOAD_WIDTH-1:0] right_payload,
   output logic                     lt,
   output logic [PRIO_WIDTH-1:0]    prio,
   output logic [PAYLOAD_WIDTH-1:0] payload
);
   import spq_pkg::*;

   logic [PRIO_WIDTH-1:0]    prio_ff;
   logic [PRIO_WIDTH-1:0]    prio_in;
   logic [PAYLOAD_WIDTH-1:0] payload_ff;
   logic [PAYLOAD_WIDTH-1:0] payload_in;

   // An occupied entry with a strictly smaller priority stays in place.
   assign lt = occupied && (prio_ff < new_prio);

   always_comb begin
      prio_in    = prio_ff;
      payload_in = payload_ff;
      if (ctl.push && !lt) begin
         if (left_lt) begin
            prio_in    = new_prio;
            payload_in = new_payload;
         end else begin
            prio_in    = left_prio;
            payload_in = left_payload;
         end
      end else if (ctl.pop) begin
         prio_in    = right_prio;
         payload_in = right_payload;
      end
   end

   always_ff @(posedge clock) begin
      prio_ff    <= prio_in;
      payload_ff <= payload_in;
   end

   assign prio    = prio_ff;
   assign payload = payload_ff;

endmodule

### rtl/sorted_priority_queue_core.sv
// Top level of the sorted priority queue: a chain of DEPTH cells, the entry
// count, and the registered response. Depends on spq_pkg, spq_if, spq_cell.
//
//   Channel   Direction  Transaction
//   req_bus   in         mode, payload, prio
//   rsp_bus   out        took_item, out_payload, out_prio, status, occupancy
//
// The cells compare and shift in parallel,
// and the response appears in the cycle after acceptance.
// One transaction per cycle is sustained while the response side takes them.
// A held response stalls the request side only while rsp_bus.ready is low.
// Synchronous reset empties the queue; entry storage itself is not cleared.
module sorted_priority_queue_core #(
   parameter int DEPTH         = spq_pkg::DEPTH_DEFAULT,
   parameter int PAYLOAD_WIDTH = spq_pkg::PAYLOAD_WIDTH_DEFAULT,
   parameter int PRIO_WIDTH    = spq_pkg::PRIO_WIDTH_DEFAULT
) (
   input logic     clock,
   input logic     reset,
   spq_req_if.sink   req_bus,
   spq_rsp_if.source rsp_bus
);
   import spq_pkg::*;

   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);
   localparam logic [COUNT_WIDTH-1:0] FULL_COUNT = COUNT_WIDTH'(DEPTH);

   logic [COUNT_WIDTH-1:0]   count_ff;
   logic [COUNT_WIDTH-1:0]   count_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic                     took_item_ff;
   logic                     took_item_in;
   logic [PAYLOAD_WIDTH-1:0] out_payload_ff;
   logic [PAYLOAD_WIDTH-1:0] out_payload_in;
   logic [PRIO_WIDTH-1:0]    out_prio_ff;
   logic [PRIO_WIDTH-1:0]    out_prio_in;
   logic [STATUS_WIDTH-1:0]  status_ff;
   logic [STATUS_WIDTH-1:0]  status_in;
   logic [COUNT_WIDTH-1:0]   occupancy_ff;
   logic [COUNT_WIDTH-1:0]   occupancy_in;

   logic                     accept;
   logic                     full;
   logic                     empty;
   spq_ctl_type              ctl;

   logic [DEPTH-1:0]         cell_lt;
   logic [PRIO_WIDTH-1:0]    cell_prio    [DEPTH];
   logic [PAYLOAD_WIDTH-1:0] cell_payload [DEPTH];

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;
   assign full          = (count_ff == FULL_COUNT);
   assign empty         = (count_ff == '0);
   assign ctl.push      = accept && (req_bus.mode == MODE_ENQUEUE) && !full;
   assign ctl.pop       = accept && (req_bus.mode == MODE_DEQUEUE) && !empty;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                     left_lt;
      logic [PRIO_WIDTH-1:0]    left_prio;
      logic [PAYLOAD_WIDTH-1:0] left_payload;
      logic [PRIO_WIDTH-1:0]    right_prio;
      logic [PAYLOAD_WIDTH-1:0] right_payload;

      if (i == 0) begin : g_head
         assign left_lt      = 1'b1;
         assign left_prio    = '0;
         assign left_payload = '0;
      end else begin : g_body
         assign left_lt      = cell_lt[i-1];
         assign left_prio    = cell_prio[i-1];
         assign left_payload = cell_payload[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_prio    = '0;
         assign right_payload = '0;
      end else begin : g_inner
         assign right_prio    = cell_prio[i+1];
         assign right_payload = cell_payload[i+1];
      end

      spq_cell #(
         .PAYLOAD_WIDTH (PAYLOAD_WIDTH),
         .PRIO_WIDTH    (PRIO_WIDTH)
      ) u_cell (
         .clock         (clock),
         .ctl           (ctl),
         .occupied      (count_ff > COUNT_WIDTH'(i)),
         .new_prio      (req_bus.prio),
         .new_payload   (req_bus.payload),
         .left_lt       (left_lt),
         .left_prio     (left_prio),
         .left_payload  (left_payload),
         .right_prio    (right_prio),
         .right_payload (right_payload),
         .lt            (cell_lt[i]),
         .prio          (cell_prio[i]),
         .payload       (cell_payload[i])
      );
   end

   always_comb begin
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      took_item_in   = took_item_ff;
      out_payload_in = out_payload_ff;
      out_prio_in    = out_prio_ff;
      status_in      = status_ff;
      occupancy_in   = occupancy_ff;
      if (ctl.push) begin
         count_in = count_ff + 1'b1;
      end else if (ctl.pop) begin
         count_in = count_ff - 1'b1;
      end
      if (accept) begin
         rsp_valid_in   = 1'b1;
         took_item_in   = ctl.pop;
         out_payload_in = ctl.pop ? cell_payload[0] : '0;
         out_prio_in    = ctl.pop ? cell_prio[0] : '0;
         occupancy_in   = count_in;
         if (req_bus.mode == MODE_ENQUEUE) begin
            status_in = full ? STATUS_FULL : STATUS_OK;
         end else begin
            status_in = empty ? STATUS_EMPTY : STATUS_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      took_item_ff   <= took_item_in;
      out_payload_ff <= out_payload_in;
      out_prio_ff    <= out_prio_in;
      status_ff      <= status_in;
      occupancy_ff   <= occupancy_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.took_item   = took_item_ff;
   assign rsp_bus.out_payload = out_payload_ff;
   assign rsp_bus.out_prio    = out_prio_ff;
   assign rsp_bus.status      = status_ff;
   assign rsp_bus.occupancy   = occupancy_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("Entry count exceeds the queue depth.");

   a_push_grows : assert property (@(posedge clock) disable iff (reset)
      ctl.push |=> count_ff == $past(count_ff) + 1'b1)
      else $error("Accepted enqueue did not grow the queue.");

   a_pop_shrinks : assert property (@(posedge clock) disable iff (reset)
      ctl.pop |=> count_ff == $past(count_ff) - 1'b1)
      else $error("Accepted dequeue did not shrink the queue.");

   a_took_ok : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && took_item_ff |-> status_ff == STATUS_OK && occupancy_ff != FULL_COUNT)
      else $error("Returned entry carries an inconsistent status or occupancy.");

endmodule
